[src/cie_pkg.sv]
package cie_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned WIDE_W   = 33;
    localparam int unsigned QUO_W    = 24;
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT   = 8'd0,
        REG_CLIP_RIGHT  = 8'd1,
        REG_CLIP_TOP    = 8'd2,
        REG_CLIP_BOTTOM = 8'd3
    } reg_idx_t;

    // Item as it travels down the divider chain.
    typedef struct packed {
        logic              hit;
        logic              horiz;
        logic [WORD_W-1:0] bound;
        logic [WIDE_W-1:0] den;
        logic [WIDE_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [WORD_W-1:0] a_free;
        logic [WIDE_W-1:0] d_free;
        logic [WORD_W-1:0] a_z;
        logic [WIDE_W-1:0] d_z;
        logic [WORD_W-1:0] a_u;
        logic [WIDE_W-1:0] d_u;
        logic [WORD_W-1:0] a_v;
        logic [WIDE_W-1:0] d_v;
    } div_item_t;

    // Item after the scaling multipliers.
    typedef struct packed {
        logic              hit;
        logic              horiz;
        logic [WORD_W-1:0] bound;
        logic [WORD_W-1:0] a_free;
        logic [WIDE_W-1:0] dl_free;
        logic [WORD_W-1:0] a_z;
        logic [WIDE_W-1:0] dl_z;
        logic [WORD_W-1:0] a_u;
        logic [WIDE_W-1:0] dl_u;
        logic [WORD_W-1:0] a_v;
        logic [WIDE_W-1:0] dl_v;
    } prod_item_t;

    function automatic logic [WIDE_W-1:0] mag33(input logic [WIDE_W-1:0] v);
        mag33 = v[WIDE_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

[src/cie_ifs.sv]
interface cie_edge_if;
    import cie_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        side;
    logic [WORD_W-1:0] start_x;
    logic [WORD_W-1:0] start_y;
    logic [WORD_W-1:0] start_z;
    logic [WORD_W-1:0] start_u;
    logic [WORD_W-1:0] start_v;
    logic [WORD_W-1:0] end_x;
    logic [WORD_W-1:0] end_y;
    logic [WORD_W-1:0] end_z;
    logic [WORD_W-1:0] end_u;
    logic [WORD_W-1:0] end_v;
    modport source (output valid, side, start_x, start_y, start_z, start_u, start_v,
                    end_x, end_y, end_z, end_u, end_v, input ready);
    modport sink (input valid, side, start_x, start_y, start_z, start_u, start_v,
                  end_x, end_y, end_z, end_u, end_v, output ready);
endinterface

interface cie_result_if;
    import cie_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [WORD_W-1:0] out_x;
    logic [WORD_W-1:0] out_y;
    logic [WORD_W-1:0] out_z;
    logic [WORD_W-1:0] out_u;
    logic [WORD_W-1:0] out_v;
    modport source (output valid, hit, out_x, out_y, out_z, out_u, out_v, input ready);
    modport sink (input valid, hit, out_x, out_y, out_z, out_u, out_v, output ready);
endinterface

interface cie_cfg_if;
    import cie_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/cie_div_cell.sv]
module cie_div_cell
    import cie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    logic          valid_reg;
    div_item_t     item_reg;
    div_item_t     item_next;
    logic [WIDE_W:0] rem2;
    logic          ge;

    // One restoring step: shift, try subtract, keep one quotient bit.
    always_comb
    begin
        rem2      = {in_item.rem, 1'b0};
        ge        = rem2 >= {1'b0, in_item.den};
        item_next = in_item;
        item_next.rem = ge ? WIDE_W'(rem2 - {1'b0, in_item.den}) : rem2[WIDE_W-1:0];
        item_next.quo = {in_item.quo[QUO_W-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[src/cie_mul_stage.sv]
module cie_mul_stage
    import cie_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  div_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_item_t out_item
);

    localparam int unsigned PROD_W = WIDE_W + QUO_W;

    logic       valid_reg;
    prod_item_t item_reg;
    prod_item_t item_next;

    // Scale one difference by t, truncating toward zero.
    function automatic logic [WIDE_W-1:0] scale(input logic [WIDE_W-1:0] d,
                                                input logic [QUO_W-1:0] t);
        logic [PROD_W-1:0] prod;
        logic [WIDE_W-1:0] p;
        prod = PROD_W'(mag33(d)) * PROD_W'(t);
        p    = WIDE_W'(prod >> FRAC_BITS);
        scale = d[WIDE_W-1] ? (~p + 1'b1) : p;
    endfunction

    always_comb
    begin
        item_next.hit     = in_item.hit;
        item_next.horiz   = in_item.horiz;
        item_next.bound   = in_item.bound;
        item_next.a_free  = in_item.a_free;
        item_next.dl_free = scale(in_item.d_free, in_item.quo);
        item_next.a_z     = in_item.a_z;
        item_next.dl_z    = scale(in_item.d_z, in_item.quo);
        item_next.a_u     = in_item.a_u;
        item_next.dl_u    = scale(in_item.d_u, in_item.quo);
        item_next.a_v     = in_item.a_v;
        item_next.dl_v    = scale(in_item.d_v, in_item.quo);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[src/clip_edge_intersect_interp.sv]
// Edge against clip line intersection with z/u/v interpolation.
//
// Channels: edge_in takes one edge beat (side plus start and end vertex),
// res_out gives one result beat per edge (hit and x, y, z, u, v; all zero on a
// miss). cfg writes the four clip bounds: index 0 left, 1 right, 2 top,
// 3 bottom; other indexes are dropped. Write cfg only while the block is empty.
//
// Throughput: one edge per cycle while res_out does not stall. The setup
// register loads at the accepting edge itself, then FRAC_BITS divider cells
// (one quotient bit each), one multiply stage and the output register follow
// before the result beat shows on res_out.
//
// Every stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stalled receiver first fills the bubbles and only then
// pushes back to edge_in. Reset empties all stages and clears the bounds to 0.
module clip_edge_intersect_interp
    import cie_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    cie_edge_if.sink  edge_in,
    cie_result_if.source res_out,
    cie_cfg_if.sink   cfg
);

    // Configuration registers
    logic [WORD_W-1:0] clip_left_reg;
    logic [WORD_W-1:0] clip_right_reg;
    logic [WORD_W-1:0] clip_top_reg;
    logic [WORD_W-1:0] clip_bottom_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_right_reg  <= '0;
            clip_top_reg    <= '0;
            clip_bottom_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CLIP_LEFT:   clip_left_reg   <= cfg.data;
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg.data;
                REG_CLIP_TOP:    clip_top_reg    <= cfg.data;
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Setup stage: pick the axis, form num and den, decide the hit.
    logic              horiz;
    logic [WORD_W-1:0] bound;
    logic [WORD_W-1:0] s_coord;
    logic [WORD_W-1:0] e_coord;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
    logic [WIDE_W-1:0] num_mag;
    logic [WIDE_W-1:0] den_mag;
    logic              hit;
    div_item_t         setup_next;
    div_item_t         setup_reg;
    logic              setup_valid_reg;
    logic              setup_ready;

    function automatic logic [WIDE_W-1:0] diff(input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] a);
        diff = {b[WORD_W-1], b} - {a[WORD_W-1], a};
    endfunction

    always_comb
    begin
        horiz = (edge_in.side == SIDE_TOP) || (edge_in.side == SIDE_BOTTOM);
        case (side_t'(edge_in.side))
            SIDE_TOP:    bound = clip_top_reg;
            SIDE_BOTTOM: bound = clip_bottom_reg;
            SIDE_LEFT:   bound = clip_left_reg;
            default:     bound = clip_right_reg;
        endcase
        s_coord = horiz ? edge_in.start_y : edge_in.start_x;
        e_coord = horiz ? edge_in.end_y : edge_in.end_x;
        num     = diff(bound, s_coord);
        den     = diff(e_coord, s_coord);
        num_mag = mag33(num);
        den_mag = mag33(den);
        // strict crossing: same sign, both nonzero, |num| < |den|
        hit = (den != '0) && (num != '0) && (num[WIDE_W-1] == den[WIDE_W-1])
              && (num_mag < den_mag);

        setup_next.hit    = hit;
        setup_next.horiz  = horiz;
        setup_next.bound  = bound;
        setup_next.den    = den_mag;
        // zero rem on a miss so the chain stays well defined
        setup_next.rem    = hit ? num_mag : '0;
        setup_next.quo    = '0;
        setup_next.a_free = horiz ? edge_in.start_x : edge_in.start_y;
        setup_next.d_free = horiz ? diff(edge_in.end_x, edge_in.start_x)
                                  : diff(edge_in.end_y, edge_in.start_y);
        setup_next.a_z    = edge_in.start_z;
        setup_next.d_z    = diff(edge_in.end_z, edge_in.start_z);
        setup_next.a_u    = edge_in.start_u;
        setup_next.d_u    = diff(edge_in.end_u, edge_in.start_u);
        setup_next.a_v    = edge_in.start_v;
        setup_next.d_v    = diff(edge_in.end_v, edge_in.start_v);
    end

    assign edge_in.ready = !setup_valid_reg || setup_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
        end
        else if (edge_in.ready)
        begin
            setup_valid_reg <= edge_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_in.ready && edge_in.valid)
        begin
            setup_reg <= setup_next;
        end
    end

    // Divider chain: one cell per quotient bit of t.
    logic      chain_valid [FRAC_BITS+1];
    logic      chain_ready [FRAC_BITS+1];
    div_item_t chain_item  [FRAC_BITS+1];

    assign chain_valid[0] = setup_valid_reg;
    assign chain_item[0]  = setup_reg;
    assign setup_ready    = chain_ready[0];

    for (genvar g = 0; g < FRAC_BITS; g++)
    begin : g_cell
        cie_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Multiply stage
    logic       mul_valid;
    logic       mul_ready;
    prod_item_t mul_item;

    cie_mul_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[FRAC_BITS]),
        .in_ready  (chain_ready[FRAC_BITS]),
        .in_item   (chain_item[FRAC_BITS]),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_item  (mul_item)
    );

    // Output register: add the deltas, place the boundary, zero a miss.
    logic              out_valid_reg;
    logic              hit_reg;
    logic              horiz_reg;
    logic [WORD_W-1:0] bound_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] z_reg;
    logic [WORD_W-1:0] u_reg;
    logic [WORD_W-1:0] v_reg;
    logic [WORD_W-1:0] free_next;
    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] y_next;
    logic [WORD_W-1:0] z_next;
    logic [WORD_W-1:0] u_next;
    logic [WORD_W-1:0] v_next;

    function automatic logic [WORD_W-1:0] add_delta(input logic [WORD_W-1:0] a,
                                                    input logic [WIDE_W-1:0] dl);
        logic [WIDE_W-1:0] sum;
        sum = {a[WORD_W-1], a} + dl;
        add_delta = sum[WORD_W-1:0];
    endfunction

    always_comb
    begin
        free_next = add_delta(mul_item.a_free, mul_item.dl_free);
        x_next    = mul_item.horiz ? free_next : mul_item.bound;
        y_next    = mul_item.horiz ? mul_item.bound : free_next;
        z_next    = add_delta(mul_item.a_z, mul_item.dl_z);
        u_next    = add_delta(mul_item.a_u, mul_item.dl_u);
        v_next    = add_delta(mul_item.a_v, mul_item.dl_v);
    end

    assign mul_ready = !out_valid_reg || res_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mul_ready)
        begin
            out_valid_reg <= mul_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && mul_valid)
        begin
            hit_reg   <= mul_item.hit;
            horiz_reg <= mul_item.horiz;
            bound_reg <= mul_item.bound;
            x_reg     <= mul_item.hit ? x_next : '0;
            y_reg     <= mul_item.hit ? y_next : '0;
            z_reg     <= mul_item.hit ? z_next : '0;
            u_reg     <= mul_item.hit ? u_next : '0;
            v_reg     <= mul_item.hit ? v_next : '0;
        end
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.hit   = hit_reg;
    assign res_out.out_x = x_reg;
    assign res_out.out_y = y_reg;
    assign res_out.out_z = z_reg;
    assign res_out.out_u = u_reg;
    assign res_out.out_v = v_reg;

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (x_reg == '0 && y_reg == '0 && z_reg == '0
                                         && u_reg == '0 && v_reg == '0))
        else $error("miss result carries nonzero data");

    a_vert_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg && !horiz_reg) |-> (x_reg == bound_reg))
        else $error("vertical hit x is off the boundary");

    a_horiz_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg && horiz_reg) |-> (y_reg == bound_reg))
        else $error("horizontal hit y is off the boundary");
`endif

endmodule

[verif/tb_clip_edge_intersect_interp.sv]
`timescale 1ns / 1ps

module tb_clip_edge_intersect_interp;
    import cie_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 3;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_EDGES = 1600;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;

    // One edge beat as the sender presents it.
    typedef struct {
        side_t        side;
        logic [31:0]  sx, sy, sz, su, sv;
        logic [31:0]  ex, ey, ez, eu, ev;
    } edge_t;

    // One result beat: hit and the clipped vertex.
    typedef struct {
        logic         hit;
        logic [31:0]  x, y, z, u, v;
    } vertex_t;

    logic clk;
    logic rst_n;

    cie_edge_if   edge_ch();
    cie_result_if res_ch();
    cie_cfg_if    cfg_ch();

    clip_edge_intersect_interp #(.FRAC_BITS(FRAC)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_ch.sink),
        .res_out (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // Window bounds as the block should hold them.
    logic signed [31:0] win_left, win_right, win_top, win_bottom;

    vertex_t clipped_q[$];
    int      errors;
    int      idle_cycles = 0;
    bit      sink_stalls;
    bit      drain_hold;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Interpolate a toward b by fraction t, truncating the step toward zero.
    function automatic logic [31:0] lerp_q16(logic signed [31:0] a, logic signed [31:0] b,
                                             logic [63:0] t);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        p;
        logic signed [63:0] r;
        d   = 64'(b) - 64'(a);
        mag = d < 0 ? 64'(-d) : 64'(d);
        p   = (mag * t) >> FRAC;
        r   = 64'(a) + (d < 0 ? -$signed(p) : $signed(p));
        return r[31:0];
    endfunction

    // Clip one edge against the line for its side.
    function automatic vertex_t clip_edge(edge_t e);
        vertex_t            r;
        logic               horiz;
        logic signed [63:0] bnd, s, f, num, den;
        logic [63:0]        anum, aden, t;
        r     = '{hit: 1'b0, x: '0, y: '0, z: '0, u: '0, v: '0};
        horiz = (e.side == SIDE_TOP) || (e.side == SIDE_BOTTOM);
        case (e.side)
            SIDE_TOP:    bnd = 64'(win_top);
            SIDE_BOTTOM: bnd = 64'(win_bottom);
            SIDE_LEFT:   bnd = 64'(win_left);
            default:     bnd = 64'(win_right);
        endcase
        s    = horiz ? 64'($signed(e.sy)) : 64'($signed(e.sx));
        f    = horiz ? 64'($signed(e.ey)) : 64'($signed(e.ex));
        num  = bnd - s;
        den  = f - s;
        anum = num < 0 ? 64'(-num) : 64'(num);
        aden = den < 0 ? 64'(-den) : 64'(den);
        if (den == 0 || num == 0 || ((num < 0) != (den < 0)) || anum >= aden)
            return r;
        t     = (anum << FRAC) / aden;
        r.hit = 1'b1;
        if (horiz)
        begin
            r.x = lerp_q16(e.sx, e.ex, t);
            r.y = bnd[31:0];
        end
        else
        begin
            r.x = bnd[31:0];
            r.y = lerp_q16(e.sy, e.ey, t);
        end
        r.z = lerp_q16(e.sz, e.ez, t);
        r.u = lerp_q16(e.su, e.eu, t);
        r.v = lerp_q16(e.sv, e.ev, t);
        return r;
    endfunction

    // Write one bound register; the block must be empty.
    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_CLIP_LEFT:   win_left   = val;
            REG_CLIP_RIGHT:  win_right  = val;
            REG_CLIP_TOP:    win_top    = val;
            REG_CLIP_BOTTOM: win_bottom = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_window(logic [31:0] l, logic [31:0] r, logic [31:0] t,
                              logic [31:0] b);
        write_bound(REG_CLIP_LEFT, l);
        write_bound(REG_CLIP_RIGHT, r);
        write_bound(REG_CLIP_TOP, t);
        write_bound(REG_CLIP_BOTTOM, b);
    endtask

    // Wait for every pending result, then let the pipe run empty.
    task automatic drain_pipe();
        while (clipped_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Present one edge and hold it until accepted. Queue the prediction
    // (or a typed-in one) at acceptance so ordering matches the pipe.
    task automatic send_edge(edge_t e, bit use_fixed, vertex_t fixed_res, bit gaps);
        if (gaps && ($urandom_range(0, 7) == 0))
        begin
            edge_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        edge_ch.valid   <= 1'b1;
        edge_ch.side    <= e.side;
        edge_ch.start_x <= e.sx;
        edge_ch.start_y <= e.sy;
        edge_ch.start_z <= e.sz;
        edge_ch.start_u <= e.su;
        edge_ch.start_v <= e.sv;
        edge_ch.end_x   <= e.ex;
        edge_ch.end_y   <= e.ey;
        edge_ch.end_z   <= e.ez;
        edge_ch.end_u   <= e.eu;
        edge_ch.end_v   <= e.ev;
        do @(posedge clk); while (!edge_ch.ready);
        clipped_q.push_back(use_fixed ? fixed_res : clip_edge(e));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7fff_ffff - $urandom_range(0, 3);
            2:       return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    // Build an edge that mostly straddles the line of its side.
    function automatic edge_t rand_edge();
        edge_t              e;
        logic signed [31:0] bnd;
        logic [31:0]        span;
        e = '{side: side_t'($urandom_range(0, 3)),
              sx: rand_word(), sy: rand_word(), sz: rand_word(), su: rand_word(),
              sv: rand_word(), ex: rand_word(), ey: rand_word(), ez: rand_word(),
              eu: rand_word(), ev: rand_word()};
        if ($urandom_range(0, 9) < 7)
        begin
            case (e.side)
                SIDE_TOP:    bnd = win_top;
                SIDE_BOTTOM: bnd = win_bottom;
                SIDE_LEFT:   bnd = win_left;
                default:     bnd = win_right;
            endcase
            span = $urandom_range(0, 3) == 0 ? $urandom() >> 1 : $urandom_range(1, 1 << 20);
            if (e.side == SIDE_TOP || e.side == SIDE_BOTTOM)
            begin
                e.sy = bnd - $urandom_range(0, span);
                e.ey = bnd + $urandom_range(0, span);
                if ($urandom_range(0, 1)) {e.sy, e.ey} = {e.ey, e.sy};
            end
            else
            begin
                e.sx = bnd - $urandom_range(0, span);
                e.ex = bnd + $urandom_range(0, span);
                if ($urandom_range(0, 1)) {e.sx, e.ex} = {e.ex, e.sx};
            end
        end
        return e;
    endfunction

    // Directed rows: window fixed at left -1, right +1, top +2, bottom -2.
    typedef struct {
        edge_t   e;
        bit      typed;
        vertex_t res;
    } row_t;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hffff_0000;
    localparam logic [31:0] MAXW = 32'h7fff_ffff;
    localparam logic [31:0] MINW = 32'h8000_0000;

    row_t rows[$];
    vertex_t miss;

    task automatic add_row(side_t sd, logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                           logic [31:0] ey, logic [31:0] a0, logic [31:0] a1,
                           bit typed, vertex_t res);
        row_t r;
        r.e = '{side: sd, sx: sx, sy: sy, sz: a0, su: ~a0, sv: a1,
                ex: ex, ey: ey, ez: a1, eu: ~a1, ev: a0};
        r.typed = typed;
        r.res   = res;
        rows.push_back(r);
    endtask

    // Result side: random stall bursts until the final stretch.
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_stalls && !drain_hold && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest pending prediction.
    always @(posedge clk)
    begin
        vertex_t expd;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (clipped_q.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: hit %0b x %h", $time,
                         res_ch.hit, res_ch.out_x);
                errors++;
            end
            else
            begin
                expd = clipped_q.pop_front();
                if (res_ch.hit !== expd.hit || res_ch.out_x !== expd.x ||
                    res_ch.out_y !== expd.y || res_ch.out_z !== expd.z ||
                    res_ch.out_u !== expd.u || res_ch.out_v !== expd.v)
                begin
                    $display("%0t: expected hit %0b x %h y %h z %h u %h v %h", $time,
                             expd.hit, expd.x, expd.y, expd.z, expd.u, expd.v);
                    $display("%0t: actual   hit %0b x %h y %h z %h u %h v %h", $time,
                             res_ch.hit, res_ch.out_x, res_ch.out_y, res_ch.out_z,
                             res_ch.out_u, res_ch.out_v);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        vertex_t hitv;
        errors        = 0;
        sink_stalls   = 1'b0;
        drain_hold    = 1'b0;
        miss          = '{hit: 1'b0, x: '0, y: '0, z: '0, u: '0, v: '0};
        win_left      = '0;
        win_right     = '0;
        win_top       = '0;
        win_bottom    = '0;
        rst_n         = 1'b0;
        edge_ch.valid = 1'b0;
        edge_ch.side  = SIDE_TOP;
        {edge_ch.start_x, edge_ch.start_y, edge_ch.start_z, edge_ch.start_u,
         edge_ch.start_v} = '0;
        {edge_ch.end_x, edge_ch.end_y, edge_ch.end_z, edge_ch.end_u, edge_ch.end_v} = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Bounds still zero after reset: a vertical edge from -1 to +1 meets y = 0
        // halfway, so attributes land at the midpoint.
        hitv = '{hit: 1'b1, x: '0, y: '0, z: 32'd50, u: ~32'd50, v: 32'd50};
        send_edge('{side: SIDE_TOP, sx: '0, sy: MONE, sz: '0, su: ~32'd0, sv: 32'd100,
                    ex: '0, ey: ONE, ez: 32'd100, eu: ~32'd100, ev: '0}, 1'b1, hitv, 1'b0);
        edge_ch.valid <= 1'b0;
        drain_pipe();

        set_window(MONE, ONE, 32'h0002_0000, 32'hfffe_0000);
        write_bound(REG_UNMAPPED, 32'hdead_beef);     // out of range index: dropped

        // Parallel, endpoint-on-line and outside rows are typed; the rest, extreme
        // rows among them, go through the predictor.
        add_row(SIDE_TOP,    MINW, 32'h0002_0000, MAXW, 32'h0002_0000, 0, 0, 1'b1, miss);
        add_row(SIDE_BOTTOM, 0, 32'hfffe_0000, 0, ONE, MAXW, MINW, 1'b1, miss);
        add_row(SIDE_LEFT,   MONE, 0, 0, 0, 0, 0, 1'b1, miss);
        add_row(SIDE_RIGHT,  0, 0, ONE, 0, 0, 0, 1'b1, miss);
        add_row(SIDE_LEFT,   MAXW, MINW, MINW, MAXW, MINW, MAXW, 1'b0, miss);
        add_row(SIDE_RIGHT,  MINW, MAXW, MAXW, MINW, MAXW, MINW, 1'b0, miss);
        add_row(SIDE_TOP,    MAXW, MINW, MINW, MAXW, MAXW, MAXW, 1'b0, miss);
        add_row(SIDE_BOTTOM, MINW, MAXW, MAXW, MINW, MINW, MINW, 1'b0, miss);
        add_row(SIDE_TOP,    0, MAXW, ONE, MAXW - 1, 0, 0, 1'b1, miss);
        add_row(SIDE_LEFT,   32'hfffe_ffff, 5, MAXW, 9, 32'd77, MAXW, 1'b0, miss);
        add_row(SIDE_RIGHT,  MAXW, 5, 32'h0000_ffff, 9, MINW, 32'd3, 1'b0, miss);
        add_row(SIDE_BOTTOM, 7, MINW, 9, 32'hfffe_0001, 1, 2, 1'b0, miss);
        add_row(SIDE_TOP,    7, 0, 9, 32'h0004_0000, ONE, MONE, 1'b0, miss);
        add_row(SIDE_LEFT,   0, 0, 32'hfffc_0000, MAXW, MAXW, MINW, 1'b0, miss);
        foreach (rows[i])
            send_edge(rows[i].e, rows[i].typed, rows[i].res, 1'b0);
        edge_ch.valid <= 1'b0;
        drain_pipe();

        // Random phases over several windows, extremes among them.
        sink_stalls = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_window(MINW, MAXW, MAXW, MINW);
                1: set_window(MAXW, MINW, MINW, MAXW);
                2: set_window(0, 0, 0, 0);
                default: set_window($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            if (ph == 5) drain_hold = 1'b1;
            for (int k = 0; k < RANDOM_EDGES / 6; k++)
            begin
                if (ph == 3 && k == 100)
                begin
                    edge_ch.valid <= 1'b0;
                    @(negedge clk);
                    while (clipped_q.size() != 0) @(negedge clk);
                end
                send_edge(rand_edge(), 1'b0, miss, ph != 5);
            end
            edge_ch.valid <= 1'b0;
            drain_pipe();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[clip_edge_intersect_interp.f]
src/cie_pkg.sv
src/cie_ifs.sv
src/cie_div_cell.sv
src/cie_mul_stage.sv
src/clip_edge_intersect_interp.sv
verif/tb_clip_edge_intersect_interp.sv
